>>> src/mwl_pkg.sv
`default_nettype none

package mwl_pkg;

  // Defaults for the top-level parameters
  localparam int unsigned MAX_LEN_DEF    = 1024;
  localparam int unsigned VALUE_BITS_DEF = 16;

  // Fixed field widths of the channels and the configuration register
  localparam int unsigned VALUE_W  = 16;
  localparam int unsigned LEN_W    = 11;
  localparam int unsigned TARGET_W = 32;

  localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(1);

endpackage

`default_nettype wire

>>> src/mwl_in_if.sv
`default_nettype none

interface mwl_in_if;
  import mwl_pkg::*;

  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               last;

  modport source (output valid, output value, output last, input ready);
  modport sink   (input valid, input value, input last, output ready);

endinterface

`default_nettype wire

>>> src/mwl_out_if.sv
`default_nettype none

interface mwl_out_if;
  import mwl_pkg::*;

  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] min_length;
  logic             overflow;

  modport source (output valid, output min_length, output overflow, input ready);
  modport sink   (input valid, input min_length, input overflow, output ready);

endinterface

`default_nettype wire

>>> src/mwl_store.sv
`default_nettype none

module mwl_store #(
  parameter int unsigned DEPTH  = mwl_pkg::MAX_LEN_DEF,
  parameter int unsigned DATA_W = mwl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [DATA_W-1:0]        wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read: data shows in the cycle after the address, when re_i is high
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/min_window_len_sum_at_least.sv
`default_nettype none
// Flow: a beat without last goes through S_CHECK, then S_POP and S_CHECK again for each element
//   popped, with S_DROP first when the window is full; the result of a last beat is in the
//   output register right after its final check cycle.
// Beats are taken one at a time; each element is written once and read at most once
//   through the window store.
// Reset: rst_ni clears control state and sets target to 1; the window store is not cleared.
module min_window_len_sum_at_least #(
  parameter int unsigned MAX_LEN    = mwl_pkg::MAX_LEN_DEF,
  parameter int unsigned VALUE_BITS = mwl_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [mwl_pkg::TARGET_W-1:0]  cfg_data_i,
  mwl_in_if.sink                             in_i,
  mwl_out_if.source                          out_o
);
  import mwl_pkg::*;

  localparam int unsigned VB    = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
  localparam int unsigned PTR_W = $clog2(MAX_LEN);
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned SUM_W = CNT_W + VB;
  localparam int unsigned CMP_W = (SUM_W > TARGET_W) ? SUM_W : TARGET_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DROP,
    S_CHECK,
    S_POP
  } state_e;

  state_e              state_q, state_d;
  logic [TARGET_W-1:0] target_q;
  logic [VB-1:0]       val_q, val_d;
  logic                last_q, last_d;
  logic [PTR_W-1:0]    head_q, head_d;
  logic [PTR_W-1:0]    tail_q, tail_d;
  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]    best_q, best_d;
  logic                ovf_q, ovf_d;
  logic                ovalid_q, ovalid_d;
  logic [LEN_W-1:0]    olen_q, olen_d;
  logic                oovf_q, oovf_d;

  logic                mem_we, mem_re;
  logic [VB-1:0]       mem_wdata, mem_rdata;
  logic [VB-1:0]       in_val;
  logic [PTR_W-1:0]    head_nxt, tail_nxt;
  logic                full, reached;

  mwl_store #(
    .DEPTH  (MAX_LEN),
    .DATA_W (VB)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (tail_q),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (head_q),
    .rdata_o (mem_rdata)
  );

  assign in_val   = in_i.value[VB-1:0];
  assign head_nxt = (head_q == PTR_W'(MAX_LEN - 1)) ? '0 : head_q + PTR_W'(1);
  assign tail_nxt = (tail_q == PTR_W'(MAX_LEN - 1)) ? '0 : tail_q + PTR_W'(1);
  assign full     = (cnt_q == CNT_W'(MAX_LEN));
  assign reached  = (cnt_q != '0) && (CMP_W'(sum_q) >= CMP_W'(target_q));

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = ovalid_q;
  assign out_o.min_length = olen_q;
  assign out_o.overflow   = oovf_q;

  always_comb begin
    state_d   = state_q;
    val_d     = val_q;
    last_d    = last_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    sum_d     = sum_q;
    best_d    = best_q;
    ovf_d     = ovf_q;
    ovalid_d  = ovalid_q;
    olen_d    = olen_q;
    oovf_d    = oovf_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = val_q;

    if (ovalid_q && out_o.ready) begin
      ovalid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          val_d  = in_val;
          last_d = in_i.last;
          if (full) begin
            // fetch the oldest entry so it can be dropped
            mem_re  = 1'b1;
            state_d = S_DROP;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = in_val;
            tail_d    = tail_nxt;
            cnt_d     = cnt_q + CNT_W'(1);
            sum_d     = sum_q + SUM_W'(in_val);
            state_d   = S_CHECK;
          end
        end
      end
      S_DROP: begin
        // drop the oldest and push the new element; count stays at full
        mem_we  = 1'b1;
        tail_d  = tail_nxt;
        head_d  = head_nxt;
        sum_d   = sum_q - SUM_W'(mem_rdata) + SUM_W'(val_q);
        ovf_d   = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (reached) begin
          if (best_q == '0 || cnt_q < best_q) begin
            best_d = cnt_q;
          end
          mem_re  = 1'b1;
          state_d = S_POP;
        end else if (!last_q) begin
          state_d = S_IDLE;
        end else if (!ovalid_q || out_o.ready) begin
          // hand off the result and clear the window
          ovalid_d = 1'b1;
          olen_d   = LEN_W'(best_q);
          oovf_d   = ovf_q;
          head_d   = '0;
          tail_d   = '0;
          cnt_d    = '0;
          sum_d    = '0;
          best_d   = '0;
          ovf_d    = 1'b0;
          state_d  = S_IDLE;
        end
      end
      S_POP: begin
        sum_d   = sum_q - SUM_W'(mem_rdata);
        head_d  = head_nxt;
        cnt_d   = cnt_q - CNT_W'(1);
        state_d = S_CHECK;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      target_q <= TARGET_RST;
      last_q   <= 1'b0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
      sum_q    <= '0;
      best_q   <= '0;
      ovf_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      if (cfg_we_i) begin
        target_q <= cfg_data_i;
      end
      last_q   <= last_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
      sum_q    <= sum_d;
      best_q   <= best_d;
      ovf_q    <= ovf_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q  <= val_d;
    olen_q <= olen_d;
    oovf_q <= oovf_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_LEN))
    else $error("window count above depth");

  a_best_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_q <= CNT_W'(MAX_LEN))
    else $error("best length above depth");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_POP) |-> (cnt_q != '0))
    else $error("pop from empty window");

  a_result_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CHECK && last_q && !reached && (!ovalid_q || out_o.ready))
      |=> (ovalid_q && cnt_q == '0 && sum_q == '0 && best_q == '0))
    else $error("result not loaded or window not cleared");

endmodule

`default_nettype wire
